[design/sito_pkg.sv]
// Shared types and constants for the sorted id/offset table.
`timescale 1ns / 1ps
package sito_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned KeyW       = 64;

  typedef enum logic [2:0] {
    ActClear    = 3'd0,
    ActLoad     = 3'd1,
    ActById     = 3'd2,
    ActByOffset = 3'd3,
    ActResolve  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0] offset;
    logic [KeyW-1:0] id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    status_e         status;
    logic [KeyW-1:0] answer;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

[design/sorted_id_offset_table.sv]
// Top level of the sorted id/offset table: config register, output register, RAM and sequencer.
//
// Holds up to 4096 (id, offset) pairs in one RAM, kept sorted by id. One word is worked on at a
// time. Clear, a load into a full table and unknown actions go straight to the result. A
// lookup or resolve is a binary search with one RAM read and one compare per step. A load
// runs the same search and then moves each pair above the insert point up one slot, one pair a
// cycle through the RAM's read and write ports. A reverse lookup scans from the lowest id,
// one entry a cycle, stopping at the first match. No clearing pass runs after reset; only
// entries below the fill count are read.
// The next input word is taken while a result still waits at the output.
`timescale 1ns / 1ps
module sorted_id_offset_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // search_key[63:0], entry_offset[127:64]
  input  logic [2:0]    s_axis_tuser,   // action[2:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // answer[63:0]
  output logic [1:0]    m_axis_tuser,   // status[1:0]
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i
);
  import sito_pkg::*;

  logic [KeyW-1:0] base_q;
  logic            out_valid_q;
  res_t            out_q;
  ram_req_t        ram_req;
  logic [EntryW-1:0] ram_rdata;
  entry_t          rdata;
  logic            res_valid;
  res_t            res;
  logic            out_free;

  assign out_free = !out_valid_q || m_axis_tready;
  assign rdata    = ram_rdata;

  sito_ram #(
    .Width(EntryW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  sito_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_action_i(s_axis_tuser),
    .in_key_i   (s_axis_tdata[63:0]),
    .in_offset_i(s_axis_tdata[127:64]),
    .base_i     (base_q),
    .ram_o      (ram_req),
    .rdata_i    (rdata),
    .res_valid_o(res_valid),
    .res_o      (res),
    .out_free_i (out_free)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (res_valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.answer;
  assign m_axis_tuser  = out_q.status;

endmodule

[design/sito_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sito_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/sito_seq.sv]
// Sequencer: binary search, sorted insert shift and linear scan over the table RAM.
`timescale 1ns / 1ps
module sito_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                in_action_i,
  input  logic [sito_pkg::KeyW-1:0] in_key_i,
  input  logic [sito_pkg::KeyW-1:0] in_offset_i,
  input  logic [sito_pkg::KeyW-1:0] base_i,
  output sito_pkg::ram_req_t        ram_o,
  input  sito_pkg::entry_t          rdata_i,
  output logic                      res_valid_o,
  output sito_pkg::res_t            res_o,
  input  logic                      out_free_i
);
  import sito_pkg::*;

  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SBs     = 7'b0000010,
    SBsWait = 7'b0000100,
    SChk    = 7'b0001000,
    SShift  = 7'b0010000,
    SScan   = 7'b0100000,
    SDone   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [AddrW-1:0] mid_q, mid_d;
  logic [CntW-1:0]  cur_q, cur_d;
  logic             rv_q, rv_d;
  logic [AddrW-1:0] wa_q, wa_d;
  logic [2:0]       act_q, act_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [KeyW-1:0]  eoff_q, eoff_d;
  res_t             res_q, res_d;
  logic [CntW-1:0]  mid;
  logic             go_right;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    cur_d    = cur_q;
    rv_d     = rv_q;
    wa_d     = wa_q;
    act_d    = act_q;
    key_d    = key_q;
    eoff_d   = eoff_q;
    res_d    = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = wa_q;
    ram_o.wdata = rdata_i;
    ram_o.raddr = '0;
    mid      = lo_q + ((hi_q - lo_q) >> 1);
    go_right = (act_q == ActLoad) ? (rdata_i.id <= key_q) : (rdata_i.id < key_q);

    case (state_q)
      SIdle: begin
        in_ready_o = rst_ni;
        if (in_valid_i) begin
          act_d  = in_action_i;
          key_d  = in_key_i;
          eoff_d = in_offset_i;
          lo_d   = '0;
          hi_d   = count_q;
          cur_d  = '0;
          rv_d   = 1'b0;
          res_d  = '{status: StMiss, answer: '0};
          case (in_action_i)
            ActClear: begin
              count_d = '0;
              res_d   = '{status: StOk, answer: '0};
              state_d = SDone;
            end
            ActLoad: begin
              if (count_q >= CntW'(TableDepth)) begin
                res_d   = '{status: StFull, answer: '0};
                state_d = SDone;
              end else begin
                state_d = SBs;
              end
            end
            ActById, ActResolve: state_d = SBs;
            ActByOffset: state_d = SScan;
            default: state_d = SDone;
          endcase
        end
      end
      SBs: begin
        if (lo_q < hi_q) begin
          ram_o.raddr = mid[AddrW-1:0];
          mid_d       = mid[AddrW-1:0];
          state_d     = SBsWait;
        end else if (act_q == ActLoad) begin
          cur_d   = count_q;
          rv_d    = 1'b0;
          state_d = SShift;
        end else if (lo_q < count_q) begin
          ram_o.raddr = lo_q[AddrW-1:0];
          state_d     = SChk;
        end else begin
          state_d = SDone;
        end
      end
      SBsWait: begin
        if (go_right) begin
          lo_d = {1'b0, mid_q} + CntW'(1);
        end else begin
          hi_d = {1'b0, mid_q};
        end
        state_d = SBs;
      end
      SChk: begin
        if (rdata_i.id == key_q) begin
          res_d.status = StOk;
          res_d.answer = (act_q == ActResolve) ? base_i + rdata_i.offset : rdata_i.offset;
        end
        state_d = SDone;
      end
      SShift: begin
        // entry read last cycle moves up by one slot
        if (rv_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = wa_q;
          ram_o.wdata = rdata_i;
        end
        if (cur_q > lo_q) begin
          ram_o.raddr = cur_q[AddrW-1:0] - AddrW'(1);
          wa_d        = cur_q[AddrW-1:0];
          cur_d       = cur_q - CntW'(1);
          rv_d        = 1'b1;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = lo_q[AddrW-1:0];
            ram_o.wdata = '{offset: eoff_q, id: key_q};
            count_d     = count_q + CntW'(1);
            res_d       = '{status: StOk, answer: '0};
            state_d     = SDone;
          end
        end
      end
      SScan: begin
        if (rv_q && (rdata_i.offset == key_q)) begin
          res_d   = '{status: StOk, answer: rdata_i.id};
          rv_d    = 1'b0;
          state_d = SDone;
        end else if (cur_q < count_q) begin
          ram_o.raddr = cur_q[AddrW-1:0];
          cur_d       = cur_q + CntW'(1);
          rv_d        = 1'b1;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            state_d = SDone;
          end
        end
      end
      SDone: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    cur_q  <= cur_d;
    wa_q   <= wa_d;
    act_q  <= act_d;
    key_q  <= key_d;
    eoff_q <= eoff_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule
